[rtl/psm_pkg.sv]
// Shared constants and control types for the PS/2 mouse command and report engine.
package psm_pkg;

  localparam int FifoDepthDefault = 64;
  localparam int AccumBitsDefault = 16;

  localparam logic [1:0] OP_HOST  = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;
  localparam logic [1:0] OP_ABORT = 2'd3;

  localparam logic [7:0] CMD_RESET    = 8'hFF;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_DISABLE  = 8'hF5;
  localparam logic [7:0] CMD_ENABLE   = 8'hF4;
  localparam logic [7:0] CMD_GET_ID   = 8'hF2;
  localparam logic [7:0] CMD_READ     = 8'hEB;
  localparam logic [7:0] CMD_STREAM   = 8'hEA;
  localparam logic [7:0] CMD_REMOTE   = 8'hF0;
  localparam logic [7:0] CMD_SCALE1   = 8'hE6;
  localparam logic [7:0] CMD_SCALE2   = 8'hE7;
  localparam logic [7:0] CMD_STATUS   = 8'hE9;
  localparam logic [7:0] CMD_RATE     = 8'hF3;
  localparam logic [7:0] CMD_RES      = 8'hE8;

  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_RESEND = 8'hFE;
  localparam logic [7:0] BYTE_BAT    = 8'hAA;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  // Source of a FIFO push.
  localparam logic [2:0] SRC_ACK    = 3'd0;
  localparam logic [2:0] SRC_RESEND = 3'd1;
  localparam logic [2:0] SRC_BAT    = 3'd2;
  localparam logic [2:0] SRC_ZERO   = 3'd3;
  localparam logic [2:0] SRC_STATUS = 3'd4;
  localparam logic [2:0] SRC_RES    = 3'd5;
  localparam logic [2:0] SRC_RATE   = 3'd6;
  localparam logic [2:0] SRC_PKT    = 3'd7;

  typedef struct packed {
    logic       push;
    logic [2:0] src;
    logic [1:0] pkt_idx;
    logic       out_clear;
    logic       do_host;
    logic       do_move;
    logic       do_fetch;
    logic       do_abort;
    logic       pkt_clear;
  } psm_cmd_t;

  typedef struct packed {
    logic pkt_allowed;
    logic read_cmd;
    logic awaiting;
  } psm_stat_t;

endpackage

[rtl/psm_datapath.sv]
// Datapath: response FIFO, mode flags, motion accumulators and packet builder.
module psm_datapath #(
  parameter int FIFO_DEPTH = psm_pkg::FifoDepthDefault,
  parameter int ACCUM_BITS = psm_pkg::AccumBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  psm_pkg::psm_cmd_t cmd,
  output psm_pkg::psm_stat_t stat,
  input  logic [7:0]        host_byte,
  input  logic [11:0]       move_x,
  input  logic [11:0]       move_y,
  input  logic [2:0]        buttons_in,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic              motion_accepted,
  output logic [6:0]        queue_level
);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH = CW'(FIFO_DEPTH);
  localparam logic [CW-1:0] ROOM = CW'(FIFO_DEPTH - 3);
  localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
  localparam logic signed [ACCUM_BITS-1:0] AMAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
  localparam logic signed [ACCUM_BITS-1:0] AMIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};
  localparam logic signed [ACCUM_BITS-1:0] P255 = ACCUM_BITS'(255);
  localparam logic signed [ACCUM_BITS-1:0] N255 = -ACCUM_BITS'(255);

  logic [7:0] mem [FIFO_DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;
  logic resume_valid, inflight_valid;
  logic [7:0] resume_byte, inflight_byte;
  logic streaming_on, remote_on, scaling, awaiting, param_res;
  logic [7:0] sample_rate;
  logic [1:0] resolution_code;
  logic signed [ACCUM_BITS-1:0] accum_x, accum_y;
  logic [2:0] button_state;
  logic motion_pending;

  logic signed [ACCUM_BITS-1:0] dx, dy, sx, sy;
  logic signed [ACCUM_BITS:0] wx, wy;
  logic [7:0] pkt0, push_byte, head;
  logic push_ok, is_param;

  always_comb begin
    dx = accum_x > P255 ? P255 : (accum_x < N255 ? N255 : accum_x);
    dy = accum_y > P255 ? P255 : (accum_y < N255 ? N255 : accum_y);
    pkt0 = {dy != accum_y, dx != accum_x, dy[ACCUM_BITS-1], dx[ACCUM_BITS-1],
            1'b1, button_state};
    wx = {accum_x[ACCUM_BITS-1], accum_x} + (ACCUM_BITS+1)'($signed(move_x));
    wy = {accum_y[ACCUM_BITS-1], accum_y} + (ACCUM_BITS+1)'($signed(move_y));
    sx = wx > (ACCUM_BITS+1)'(AMAX) ? AMAX :
         (wx < (ACCUM_BITS+1)'(AMIN) ? AMIN : wx[ACCUM_BITS-1:0]);
    sy = wy > (ACCUM_BITS+1)'(AMAX) ? AMAX :
         (wy < (ACCUM_BITS+1)'(AMIN) ? AMIN : wy[ACCUM_BITS-1:0]);
    case (cmd.src)
      psm_pkg::SRC_ACK:    push_byte = psm_pkg::BYTE_ACK;
      psm_pkg::SRC_RESEND: push_byte = psm_pkg::BYTE_RESEND;
      psm_pkg::SRC_BAT:    push_byte = psm_pkg::BYTE_BAT;
      psm_pkg::SRC_ZERO:   push_byte = psm_pkg::BYTE_ZERO;
      psm_pkg::SRC_STATUS: push_byte = {1'b0, remote_on, streaming_on, scaling, 1'b0,
                                        button_state};
      psm_pkg::SRC_RES:    push_byte = {6'd0, resolution_code};
      psm_pkg::SRC_RATE:   push_byte = sample_rate;
      default: begin
        case (cmd.pkt_idx)
          2'd0:    push_byte = pkt0;
          2'd1:    push_byte = dx[7:0];
          default: push_byte = dy[7:0];
        endcase
      end
    endcase
    push_ok = cmd.push && count < DEPTH;
    is_param = cmd.do_host && awaiting;
    stat.pkt_allowed = streaming_on && !remote_on && motion_pending && count <= ROOM;
    stat.read_cmd = host_byte == psm_pkg::CMD_READ;
    stat.awaiting = awaiting;
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem[wr_ptr] <= push_byte;
    head <= mem[rd_ptr];
  end

  assign queue_level = 7'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0; wr_ptr <= '0; count <= '0;
      resume_valid <= 1'b0; resume_byte <= 8'd0;
      inflight_valid <= 1'b0; inflight_byte <= 8'd0;
      streaming_on <= 1'b1; remote_on <= 1'b0; scaling <= 1'b0;
      awaiting <= 1'b0; param_res <= 1'b0;
      sample_rate <= 8'd100; resolution_code <= 2'd2;
      accum_x <= '0; accum_y <= '0; button_state <= 3'd0; motion_pending <= 1'b0;
      tx_valid <= 1'b0; tx_byte <= 8'd0; motion_accepted <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd.pkt_clear) begin
        accum_x <= '0; accum_y <= '0; motion_pending <= 1'b0;
      end
      if (cmd.do_abort && inflight_valid) begin
        resume_valid <= 1'b1; resume_byte <= inflight_byte; inflight_valid <= 1'b0;
      end
      if (cmd.out_clear) begin
        tx_valid <= 1'b0; tx_byte <= 8'd0; motion_accepted <= 1'b0;
      end
      if (cmd.do_move) begin
        tx_valid <= 1'b0; tx_byte <= 8'd0;
        motion_accepted <= streaming_on && !remote_on;
        if (streaming_on && !remote_on) begin
          accum_x <= sx; accum_y <= sy; button_state <= buttons_in;
          motion_pending <= 1'b1;
        end
      end
      if (cmd.do_abort) begin
        tx_valid <= 1'b0; tx_byte <= 8'd0; motion_accepted <= 1'b0;
      end
      if (cmd.do_fetch) begin
        motion_accepted <= 1'b0;
        if (resume_valid) begin
          resume_valid <= 1'b0; tx_valid <= 1'b1; tx_byte <= resume_byte;
          inflight_valid <= 1'b1; inflight_byte <= resume_byte;
        end else if (count != '0) begin
          tx_valid <= 1'b1; tx_byte <= head;
          inflight_valid <= 1'b1; inflight_byte <= head;
          rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
        end else begin
          tx_valid <= 1'b0; tx_byte <= 8'd0; inflight_valid <= 1'b0;
        end
      end
      count <= count + CW'(push_ok) - CW'(cmd.do_fetch && !resume_valid && count != '0);
      if (cmd.do_host) begin
        tx_valid <= 1'b0; tx_byte <= 8'd0; motion_accepted <= 1'b0;
        inflight_valid <= 1'b0;
        if (is_param) begin
          awaiting <= 1'b0; param_res <= 1'b0;
          if (param_res) resolution_code <= host_byte[1:0];
          else sample_rate <= host_byte;
        end else begin
          case (host_byte)
            psm_pkg::CMD_RESET, psm_pkg::CMD_DEFAULTS: begin
              streaming_on <= 1'b0; remote_on <= 1'b0; scaling <= 1'b0;
              awaiting <= 1'b0; param_res <= 1'b0;
              sample_rate <= 8'd100; resolution_code <= 2'd2;
              accum_x <= '0; accum_y <= '0; button_state <= 3'd0;
              motion_pending <= 1'b0;
            end
            psm_pkg::CMD_DISABLE: streaming_on <= 1'b0;
            psm_pkg::CMD_ENABLE: begin
              streaming_on <= 1'b1; remote_on <= 1'b0;
            end
            psm_pkg::CMD_STREAM: remote_on <= 1'b0;
            psm_pkg::CMD_REMOTE: begin
              remote_on <= 1'b1; streaming_on <= 1'b0;
            end
            psm_pkg::CMD_SCALE1: scaling <= 1'b0;
            psm_pkg::CMD_SCALE2: scaling <= 1'b1;
            psm_pkg::CMD_RATE: begin
              awaiting <= 1'b1; param_res <= 1'b0;
            end
            psm_pkg::CMD_RES: begin
              awaiting <= 1'b1; param_res <= 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end
endmodule

[rtl/psm_ctrl.sv]
// Controller: sequences the FIFO pushes and the state update of one item.
module psm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               device_enable,
  input  logic [1:0]         opcode,
  input  logic [7:0]         host_byte,
  input  psm_pkg::psm_stat_t stat,
  output psm_pkg::psm_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_PKT  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next, pkt_exit;
  logic [1:0] op, idx, idx_next, nresp, nresp_next;
  logic [2:0] rsrc [4];
  logic [2:0] rsrc_next [4];
  logic readpkt, readpkt_next, pktreq, pktreq_next;

  always_comb begin
    state_next = state; idx_next = idx; nresp_next = nresp;
    readpkt_next = readpkt; pktreq_next = pktreq;
    for (int i = 0; i < 4; i++) rsrc_next[i] = rsrc[i];
    cmd = '0;
    cmd.src = psm_pkg::SRC_PKT;
    pkt_exit = (pktreq && op != psm_pkg::OP_FETCH) ? S_DONE : S_EXEC;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          idx_next = 2'd0; readpkt_next = 1'b0; pktreq_next = 1'b0; nresp_next = 2'd0;
          rsrc_next[0] = psm_pkg::SRC_ACK;
          rsrc_next[1] = psm_pkg::SRC_ZERO;
          rsrc_next[2] = psm_pkg::SRC_ZERO;
          rsrc_next[3] = psm_pkg::SRC_ZERO;
          if (!device_enable || opcode == psm_pkg::OP_ABORT) begin
            state_next = S_EXEC;
          end else if (opcode == psm_pkg::OP_HOST) begin
            state_next = S_RESP;
            if (!stat.awaiting) begin
              case (host_byte)
                psm_pkg::CMD_RESET: begin
                  nresp_next = 2'd2; rsrc_next[1] = psm_pkg::SRC_BAT;
                end
                psm_pkg::CMD_GET_ID: nresp_next = 2'd1;
                psm_pkg::CMD_READ: readpkt_next = 1'b1;
                psm_pkg::CMD_STATUS: begin
                  nresp_next = 2'd3;
                  rsrc_next[1] = psm_pkg::SRC_STATUS;
                  rsrc_next[2] = psm_pkg::SRC_RES;
                  rsrc_next[3] = psm_pkg::SRC_RATE;
                end
                psm_pkg::CMD_DEFAULTS, psm_pkg::CMD_DISABLE, psm_pkg::CMD_ENABLE,
                psm_pkg::CMD_STREAM, psm_pkg::CMD_REMOTE, psm_pkg::CMD_SCALE1,
                psm_pkg::CMD_SCALE2, psm_pkg::CMD_RATE, psm_pkg::CMD_RES: ;
                default: rsrc_next[0] = psm_pkg::SRC_RESEND;
              endcase
            end
          end else if (opcode == psm_pkg::OP_FETCH) begin
            pktreq_next = 1'b1; state_next = S_PKT;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_RESP: begin
        cmd.push = 1'b1; cmd.src = rsrc[idx];
        idx_next = idx + 2'd1;
        if (idx == nresp) begin
          idx_next = 2'd0;
          state_next = S_EXEC;
          if (readpkt) state_next = S_PKT;
        end
      end
      S_PKT: begin
        if (idx == 2'd0 && !(readpkt || stat.pkt_allowed)) begin
          state_next = pkt_exit;
        end else begin
          cmd.push = 1'b1; cmd.pkt_idx = idx;
          idx_next = idx + 2'd1;
          if (idx == 2'd2) begin
            cmd.pkt_clear = 1'b1; idx_next = 2'd0;
            readpkt_next = 1'b0;
            state_next = pkt_exit;
          end
        end
      end
      S_EXEC: begin
        cmd.out_clear = 1'b1;
        cmd.do_host = device_enable && op == psm_pkg::OP_HOST;
        cmd.do_move = device_enable && op == psm_pkg::OP_MOVE;
        cmd.do_fetch = device_enable && op == psm_pkg::OP_FETCH;
        cmd.do_abort = device_enable && op == psm_pkg::OP_ABORT;
        state_next = S_DONE;
        if (device_enable && !pktreq &&
            (op == psm_pkg::OP_HOST || op == psm_pkg::OP_MOVE)) begin
          pktreq_next = 1'b1;
          state_next = S_PKT;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // After a host byte or motion, the packet check runs with the new state.
  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= 2'd0; nresp <= 2'd0; readpkt <= 1'b0; pktreq <= 1'b0;
    end else begin
      state <= state_next; idx <= idx_next; nresp <= nresp_next;
      readpkt <= readpkt_next; pktreq <= pktreq_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) rsrc[i] <= rsrc_next[i];
    if (state == S_IDLE && in_fire) begin
      op <= opcode;
    end
  end
endmodule

[rtl/ps2_mouse_command_report_engine.sv]
// Top level of the PS/2 mouse command and report engine.
// One item is taken at a time and its result follows the input transfer in these steps:
// a host command pushes up to four response bytes at one FIFO write a cycle, a motion
// packet adds three more writes, and the result register then holds the output until its
// transfer; the next input is taken only after that transfer.
module ps2_mouse_command_report_engine #(
  parameter int FIFO_DEPTH = psm_pkg::FifoDepthDefault,
  parameter int ACCUM_BITS = psm_pkg::AccumBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  host_byte,
  input  logic [11:0] move_x,
  input  logic [11:0] move_y,
  input  logic [2:0]  buttons_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        motion_accepted,
  output logic [6:0]  queue_level
);
  psm_pkg::psm_cmd_t cmd;
  psm_pkg::psm_stat_t stat;
  logic busy, done, device_enable, in_fire;
  logic [7:0] hb_q;
  logic [11:0] mx_q, my_q;
  logic [2:0] bt_q;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy && !out_valid;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_enable <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) device_enable <= cfg_data;
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hb_q <= host_byte; mx_q <= move_x; my_q <= move_y; bt_q <= buttons_in;
    end
  end

  psm_ctrl u_ctrl (
    .clk, .rst, .in_fire, .device_enable, .opcode, .host_byte, .stat, .cmd, .busy, .done
  );

  psm_datapath #(.FIFO_DEPTH(FIFO_DEPTH), .ACCUM_BITS(ACCUM_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .host_byte(hb_q), .move_x(mx_q), .move_y(my_q),
    .buttons_in(bt_q), .tx_valid, .tx_byte, .motion_accepted, .queue_level
  );
endmodule

[rtl/psm_checker.sv]
// Port-level checker for the PS/2 mouse engine, bound to the top level.
module psm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       motion_accepted
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_valid) |-> tx_byte == 8'd0) else $error("tx_byte not zero");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tx_valid && motion_accepted)) else $error("both flags set");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(tx_byte))
    else $error("result dropped");
endmodule

bind ps2_mouse_command_report_engine psm_checker u_psm_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .tx_valid, .tx_byte,
  .motion_accepted
);
